[sv/koc_pkg.sv]
// ----------------------------------------------------------------------------
// koc_pkg
// shared constants, types and register codes of the keyword occurrence
// classifier
// ----------------------------------------------------------------------------
`default_nettype none

package koc_pkg;

  // fixed field and register widths
  localparam int KOC_SLOTS   = 7;    // keyword slots in the register map
  localparam int REG_W       = 64;   // keyword register width
  localparam int REG_IDX_W   = 3;    // register index width
  localparam int IN_DATA_W   = 8;    // text byte
  localparam int OUT_DATA_W  = 16;   // word_index + best_count
  localparam int COUNT_OUT_W = 13;   // best_count field
  localparam int INDEX_W     = 3;    // word_index field and slot numbers

  // parameter defaults
  localparam int MAX_WORDS_DEF  = 7;
  localparam int WORD_BYTES_DEF = 8;
  localparam int MAX_LINE_DEF   = 4096;

  // register map
  localparam logic [REG_IDX_W-1:0] REG_WORD_A       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WORDS_IN_USE = 3'd7;

  localparam logic [INDEX_W-1:0]   WORDS_IN_USE_RST = 3'd7;
  localparam logic [7:0]           SPACE_CHAR       = 8'h20;

  typedef logic [REG_W-1:0] word_t;

  // handed from the match stage to the count stage
  typedef struct packed {
    logic                 last;
    logic [KOC_SLOTS-1:0] hit;
  } koc_hit_t;

endpackage

`default_nettype wire

[sv/keyword_occurrence_classifier.sv]
// ----------------------------------------------------------------------------
// keyword_occurrence_classifier
// counts overlapping keyword occurrences over a line and names the busiest slot
// ----------------------------------------------------------------------------
// path: a line-end transfer on the input reaches out_* through the match
//   register, then the count and result register
// throughput: one byte per cycle, set by the single count update per cycle;
//   bytes keep flowing while a result waits, but a line end then stalls
// reset: rst_n low clears history, counts, keyword slots (to empty) and
//   words_in_use (to 7); the block is ready on the first cycle after reset
`default_nettype none

module keyword_occurrence_classifier #(
  parameter int MAX_WORDS  = koc_pkg::MAX_WORDS_DEF,
  parameter int WORD_BYTES = koc_pkg::WORD_BYTES_DEF,
  parameter int MAX_LINE   = koc_pkg::MAX_LINE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [koc_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] text_byte
  input  wire logic [0:0]                        in_tuser,   // [0] byte_present
  input  wire logic                              in_tlast,   // line_end
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [koc_pkg::OUT_DATA_W-1:0]         out_tdata,  // [2:0] word_index,
                                                             // [15:3] best_count
  output logic [0:0]                             out_tuser,  // [0] found
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [koc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [koc_pkg::REG_W-1:0]         cfg_data
);
  import koc_pkg::*;

  word_t                  word_r [MAX_WORDS];
  logic [INDEX_W-1:0]     wiu_r;
  logic [INDEX_W-1:0]     n_active;
  logic                   in_xfer;
  logic                   advance;
  logic                   stage_valid;
  koc_hit_t               stage;
  logic                   found;
  logic [INDEX_W-1:0]     word_index;
  logic [COUNT_OUT_W-1:0] best_count;

  // keyword slots; writes to slots this build does not hold are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORDS; i++) word_r[i] <= '0;
      wiu_r <= WORDS_IN_USE_RST;
    end else if (cfg_we) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        if (cfg_index == REG_WORD_A + REG_IDX_W'(i)) word_r[i] <= cfg_data;
      end
      if (cfg_index == REG_WORDS_IN_USE) wiu_r <= cfg_data[INDEX_W-1:0];
    end
  end

  // slots searched, capped at what is built
  assign n_active = (wiu_r > INDEX_W'(MAX_WORDS)) ? INDEX_W'(MAX_WORDS) : wiu_r;

  // the match register empties every cycle unless a line end finds the
  // result register full and not being taken
  assign advance   = stage_valid && (!stage.last || !out_tvalid || out_tready);
  assign in_tready = !stage_valid || advance;
  assign in_xfer   = in_tvalid && in_tready;

  koc_match #(
    .MAX_WORDS  (MAX_WORDS),
    .WORD_BYTES (WORD_BYTES)
  ) u_match (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_xfer),
    .advance      (advance),
    .text_byte    (in_tdata[7:0]),
    .byte_present (in_tuser[0]),
    .line_end     (in_tlast),
    .words        (word_r),
    .n_active     (n_active),
    .stage_valid  (stage_valid),
    .stage        (stage)
  );

  koc_count #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_LINE  (MAX_LINE)
  ) u_count (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .stage      (stage),
    .n_active   (n_active),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .found      (found),
    .word_index (word_index),
    .best_count (best_count)
  );

  // no match gives all-zero fields
  assign out_tdata = found ? {best_count, word_index} : '0;
  assign out_tuser = found;

endmodule

`default_nettype wire

[sv/koc_match.sv]
// ----------------------------------------------------------------------------
// koc_match
// byte history, per-slot keyword end detection; one byte per accepted cycle
// ----------------------------------------------------------------------------
`default_nettype none

module koc_match #(
  parameter int MAX_WORDS  = koc_pkg::MAX_WORDS_DEF,
  parameter int WORD_BYTES = koc_pkg::WORD_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic                         advance,
  input  wire logic [7:0]                   text_byte,
  input  wire logic                         byte_present,
  input  wire logic                         line_end,
  input  wire koc_pkg::word_t               words [MAX_WORDS],
  input  wire logic [koc_pkg::INDEX_W-1:0]  n_active,
  output logic                              stage_valid,
  output koc_pkg::koc_hit_t                 stage
);
  import koc_pkg::*;

  localparam int WIN_W = 8 * WORD_BYTES;

  logic [WIN_W-1:0]      win;
  logic [WORD_BYTES-1:0] win_ok;
  logic [KOC_SLOTS-1:0]  hit_nxt;
  logic                  valid_r, valid_nxt;
  koc_hit_t              stage_r;

  // true when keyword w (not space-led) ends on the window's newest byte
  function automatic logic ends_here(word_t w, logic [WIN_W-1:0] wn,
                                     logic [WORD_BYTES-1:0] wv);
    logic res;
    logic len_eq;
    logic ok;
    res = 1'b0;
    for (int l = 1; l <= WORD_BYTES; l++) begin
      len_eq = 1'b1;
      ok     = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (w[8*j +: 8] == 8'd0) len_eq = 1'b0;
        if (w[8*j +: 8] != wn[8*(l-1-j) +: 8] || !wv[l-1-j]) ok = 1'b0;
      end
      if (l < WORD_BYTES && w[8*l +: 8] != 8'd0) len_eq = 1'b0;
      if (len_eq && ok) res = 1'b1;
    end
    if (w[7:0] == SPACE_CHAR) res = 1'b0;
    return res;
  endfunction

  assign win[7:0]  = text_byte;
  assign win_ok[0] = 1'b1;

  generate
    if (WORD_BYTES > 1) begin : g_hist
      localparam int HB = WORD_BYTES - 1;
      logic [8*HB-1:0] hist_r, hist_nxt;
      logic [HB-1:0]   hval_r, hval_nxt;

      assign win[WIN_W-1:8]         = hist_r;
      assign win_ok[WORD_BYTES-1:1] = hval_r;

      always_comb begin
        hist_nxt = hist_r;
        hval_nxt = hval_r;
        if (accept) begin
          if (line_end) begin
            // a match never spans two lines
            hist_nxt = '0;
            hval_nxt = '0;
          end else if (byte_present) begin
            hist_nxt = {win[WIN_W-9:0]};
            hval_nxt = {win_ok[WORD_BYTES-2:0]};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          hist_r <= '0;
          hval_r <= '0;
        end else begin
          hist_r <= hist_nxt;
          hval_r <= hval_nxt;
        end
      end
    end
  endgenerate

  always_comb begin
    hit_nxt = '0;
    for (int s = 0; s < MAX_WORDS; s++) begin
      if (byte_present && INDEX_W'(s) < n_active)
        hit_nxt[s] = ends_here(words[s], win, win_ok);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept)       valid_nxt = 1'b1;
    else if (advance) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.last <= line_end;
      stage_r.hit  <= hit_nxt;
    end
  end

  assign stage_valid = valid_r;
  assign stage       = stage_r;

endmodule

`default_nettype wire

[sv/koc_count.sv]
// ----------------------------------------------------------------------------
// koc_count
// saturating occurrence counters, line-end best slot pick and result register
// ----------------------------------------------------------------------------
`default_nettype none

module koc_count #(
  parameter int MAX_WORDS = koc_pkg::MAX_WORDS_DEF,
  parameter int MAX_LINE  = koc_pkg::MAX_LINE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             advance,
  input  wire koc_pkg::koc_hit_t                stage,
  input  wire logic [koc_pkg::INDEX_W-1:0]      n_active,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic                                  found,
  output logic [koc_pkg::INDEX_W-1:0]           word_index,
  output logic [koc_pkg::COUNT_OUT_W-1:0]       best_count
);
  import koc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE + 1);

  logic [CNT_W-1:0]       cnt_r   [MAX_WORDS];
  logic [CNT_W-1:0]       cnt_inc [MAX_WORDS];
  logic [CNT_W-1:0]       best;
  logic [INDEX_W-1:0]     best_idx;
  logic                   best_hit;
  logic                   valid_r, valid_nxt;
  logic                   found_r;
  logic [INDEX_W-1:0]     idx_r;
  logic [COUNT_OUT_W-1:0] best_r;

  always_comb begin
    for (int s = 0; s < MAX_WORDS; s++) begin
      cnt_inc[s] = cnt_r[s];
      if (stage.hit[s] && cnt_r[s] < CNT_W'(MAX_LINE))
        cnt_inc[s] = cnt_r[s] + CNT_W'(1);
    end
  end

  // strictly larger wins, so the lowest slot keeps a tie
  always_comb begin
    best     = '0;
    best_idx = '0;
    best_hit = 1'b0;
    for (int s = 0; s < MAX_WORDS; s++) begin
      if (INDEX_W'(s) < n_active && cnt_inc[s] > best) begin
        best     = cnt_inc[s];
        best_idx = INDEX_W'(s);
        best_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MAX_WORDS; s++) cnt_r[s] <= '0;
    end else if (advance) begin
      for (int s = 0; s < MAX_WORDS; s++)
        cnt_r[s] <= stage.last ? '0 : cnt_inc[s];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (advance && stage.last) valid_nxt = 1'b1;
    else if (out_ready)        valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last) begin
      found_r <= best_hit;
      idx_r   <= best_idx;
      best_r  <= COUNT_OUT_W'(best);
    end
  end

  assign out_valid  = valid_r;
  assign found      = found_r;
  assign word_index = idx_r;
  assign best_count = best_r;

endmodule

`default_nettype wire

[sv/koc_checker.sv]
// ----------------------------------------------------------------------------
// koc_checker
// port-level checks on the result stream of the keyword occurrence classifier
// ----------------------------------------------------------------------------
`default_nettype none

module koc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no match carries zero slot and zero count
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 16'd0)
    else $error("no-match result with nonzero fields");

  // a match names a real slot with a nonzero count
  a_match_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[15:3] != 13'd0 && out_tdata[2:0] != 3'd7)
    else $error("match result with empty count or bad slot");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind keyword_occurrence_classifier koc_checker u_koc_checker (.*);

`default_nettype wire
